// ----- rtl/core/clt_pkg.sv -----
`default_nettype none
package clt_pkg;

  localparam int BYTE_W      = 8;
  localparam int TICKS_W     = 16;
  localparam int BEATS_W     = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  localparam logic [1:0] LANE_ONE   = 2'd0;
  localparam logic [1:0] LANE_FOUR  = 2'd1;
  localparam logic [1:0] LANE_EIGHT = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_LANE_MODE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_POLARITY = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_TICKS      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_TICKS     = 2'd3;

  typedef struct packed {
    logic              clock_level;
    logic [BYTE_W-1:0] line_drive;
    logic              line_output_enable;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/core/clt_in_if.sv -----
`default_nettype none
interface clt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] write_byte;
  logic [7:0] line_levels;

  modport source (output valid, output operation, output write_byte, output line_levels,
                  input ready);
  modport sink (input valid, input operation, input write_byte, input line_levels,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/core/clt_out_if.sv -----
`default_nettype none
interface clt_out_if;
  logic       valid;
  logic       ready;
  logic       clock_level;
  logic [7:0] line_drive;
  logic       line_output_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;

  modport source (output valid, output clock_level, output line_drive,
                  output line_output_enable, output busy_res, output done_res,
                  output read_byte, input ready);
  modport sink (input valid, input clock_level, input line_drive,
                input line_output_enable, input busy_res, input done_res,
                input read_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/clt_skid.sv -----
`default_nettype none
module clt_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  clt_pkg::res_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output clt_pkg::res_t pop_data
);
  import clt_pkg::*;

  logic head_valid;
  res_t head;
  logic spare_valid;
  res_t spare;
  logic push;
  logic pop;

  assign push_ready = !spare_valid;
  assign push       = push_valid && push_ready;
  assign pop        = head_valid && pop_ready;
  assign pop_valid  = head_valid;
  assign pop_data   = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else if (spare_valid) begin
      if (pop) begin
        head        <= spare;
        spare_valid <= 1'b0;
      end
    end else if (push) begin
      if (!head_valid || pop) begin
        head       <= push_data;
        head_valid <= 1'b1;
      end else begin
        spare       <= push_data;
        spare_valid <= 1'b1;
      end
    end else if (pop) begin
      head_valid <= 1'b0;
    end
  end

  a_spare_needs_head: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> head_valid)
    else $error("spare word held while head empty");

  a_spare_drains_first: assert property (@(posedge clk) disable iff (rst)
    spare_valid && pop |=> head_valid && head == $past(spare))
    else $error("spare word not moved to head");

  a_stall_holds_head: assert property (@(posedge clk) disable iff (rst)
    head_valid && !pop_ready |=> head_valid && $stable(head))
    else $error("head word changed while stalled");

endmodule
`default_nettype wire

// ----- rtl/core/clocked_lane_transfer_master.sv -----
// Clocked lane transfer master.
// Each word on cmd is one tick of the link waveform: an operation (plain tick,
// start read, start write), the byte to send and the sampled data line levels.
// Each accepted cmd word yields exactly one res word giving the clock level,
// the driven line levels and enable, busy, done and the assembled read byte.
// A transfer moves one byte over 1, 4 or 8 lines, least significant part first,
// in 8, 2 or 1 beats of low_ticks + high_ticks ticks each (zero counts as one).
// Registers are written through wr_en / wr_index / wr_data, by the user only
// while idle; the block does not enforce this. Res words are registered in the
// output buffer. Throughput: one cmd word per cycle while cmd.ready is high;
// the tick state updates in a single pass. A two-word output buffer absorbs a
// stall on res; cmd.ready drops only when both words are held, and rises again
// as soon as res takes one. Reset clears the transfer state, empties the output
// buffer and loads lane_mode 0, clock_polarity 1, low_ticks 1 and high_ticks 1.
`default_nettype none
module clocked_lane_transfer_master (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [clt_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [clt_pkg::CFG_DATA_W-1:0]   wr_data,
  clt_in_if.sink                            cmd,
  clt_out_if.source                         res
);
  import clt_pkg::*;

  logic [1:0]         lane_mode;
  logic               clock_polarity;
  logic [TICKS_W-1:0] low_ticks;
  logic [TICKS_W-1:0] high_ticks;

  logic               active;
  logic               reading;
  logic               second_phase;
  logic [TICKS_W-1:0] phase_ticks_left;
  logic [BEATS_W-1:0] beats_left;
  logic [BYTE_W-1:0]  send_shift;
  logic [BYTE_W-1:0]  gathered;
  logic               clock_out;
  logic [BYTE_W-1:0]  lines_out;
  logic               lines_enabled;

  logic               active_next;
  logic               reading_next;
  logic               second_phase_next;
  logic [TICKS_W-1:0] phase_ticks_left_next;
  logic [BEATS_W-1:0] beats_left_next;
  logic [BYTE_W-1:0]  send_shift_next;
  logic [BYTE_W-1:0]  gathered_next;
  logic               clock_out_next;
  logic [BYTE_W-1:0]  lines_out_next;
  logic               lines_enabled_next;

  logic [TICKS_W-1:0] low_load;
  logic [TICKS_W-1:0] high_load;
  logic [TICKS_W-1:0] ticks_dec;
  logic [BEATS_W-1:0] beats_dec;
  logic [BEATS_W-1:0] beats_load;
  logic [BYTE_W-1:0]  part_out;
  logic [BYTE_W-1:0]  shift_rest;
  logic [BYTE_W-1:0]  gathered_in;
  logic               start;
  logic               push;
  logic               push_ready;
  logic               pop_valid;
  res_t               step_res;
  res_t               pop_data;

  assign start     = (cmd.operation == OP_READ) || (cmd.operation == OP_WRITE);
  assign push      = cmd.valid && push_ready;
  assign cmd.ready = push_ready;

  assign low_load  = (low_ticks == '0) ? TICKS_W'(1) : low_ticks;
  assign high_load = (high_ticks == '0) ? TICKS_W'(1) : high_ticks;
  assign ticks_dec = (phase_ticks_left != '0) ? phase_ticks_left - TICKS_W'(1) : '0;
  assign beats_dec = (beats_left != '0) ? beats_left - BEATS_W'(1) : '0;

  always_comb begin
    case (lane_mode)
      LANE_ONE: begin
        beats_load  = BEATS_W'(8);
        part_out    = {7'd0, send_shift[0]};
        shift_rest  = {1'b0, send_shift[7:1]};
        gathered_in = {cmd.line_levels[0], gathered[7:1]};
      end
      LANE_FOUR: begin
        beats_load  = BEATS_W'(2);
        part_out    = {4'd0, send_shift[3:0]};
        shift_rest  = {4'd0, send_shift[7:4]};
        gathered_in = {cmd.line_levels[3:0], gathered[7:4]};
      end
      default: begin
        beats_load  = BEATS_W'(1);
        part_out    = send_shift;
        shift_rest  = '0;
        gathered_in = cmd.line_levels;
      end
    endcase
  end

  always_comb begin
    active_next           = active;
    reading_next          = reading;
    second_phase_next     = second_phase;
    phase_ticks_left_next = phase_ticks_left;
    beats_left_next       = beats_left;
    send_shift_next       = send_shift;
    gathered_next         = gathered;
    clock_out_next        = clock_out;
    lines_out_next        = lines_out;
    lines_enabled_next    = lines_enabled;
    step_res.done_res     = 1'b0;
    step_res.read_byte    = '0;
    if (!active) begin
      clock_out_next = clock_polarity;
      if (start) begin
        active_next           = 1'b1;
        reading_next          = (cmd.operation == OP_READ);
        second_phase_next     = 1'b0;
        phase_ticks_left_next = low_load;
        beats_left_next       = beats_load;
        gathered_next         = '0;
        clock_out_next        = !clock_polarity;
        if (cmd.operation == OP_READ) begin
          lines_enabled_next = 1'b0;
        end else begin
          send_shift_next    = cmd.write_byte;
          lines_enabled_next = 1'b1;
        end
      end
    end else begin
      phase_ticks_left_next = ticks_dec;
      if (ticks_dec == '0) begin
        if (!second_phase) begin
          if (!reading) begin
            lines_out_next  = part_out;
            send_shift_next = shift_rest;
          end
          clock_out_next        = clock_polarity;
          second_phase_next     = 1'b1;
          phase_ticks_left_next = high_load;
        end else begin
          if (reading) begin
            gathered_next = gathered_in;
          end
          beats_left_next = beats_dec;
          if (beats_dec == '0) begin
            active_next        = 1'b0;
            second_phase_next  = 1'b0;
            clock_out_next     = clock_polarity;
            step_res.done_res  = 1'b1;
            step_res.read_byte = reading ? gathered_next : '0;
          end else begin
            second_phase_next     = 1'b0;
            clock_out_next        = !clock_polarity;
            phase_ticks_left_next = low_load;
          end
        end
      end
    end
    step_res.clock_level        = clock_out_next;
    step_res.line_drive         = lines_out_next;
    step_res.line_output_enable = lines_enabled_next;
    step_res.busy_res           = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_mode      <= LANE_ONE;
      clock_polarity <= 1'b1;
      low_ticks      <= TICKS_W'(1);
      high_ticks     <= TICKS_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_LANE_MODE:      lane_mode      <= wr_data[1:0];
        REG_CLOCK_POLARITY: clock_polarity <= wr_data[0];
        REG_LOW_TICKS:      low_ticks      <= wr_data;
        REG_HIGH_TICKS:     high_ticks     <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active           <= 1'b0;
      reading          <= 1'b0;
      second_phase     <= 1'b0;
      phase_ticks_left <= '0;
      beats_left       <= '0;
      send_shift       <= '0;
      gathered         <= '0;
      clock_out        <= 1'b1;
      lines_out        <= '0;
      lines_enabled    <= 1'b0;
    end else if (push) begin
      active           <= active_next;
      reading          <= reading_next;
      second_phase     <= second_phase_next;
      phase_ticks_left <= phase_ticks_left_next;
      beats_left       <= beats_left_next;
      send_shift       <= send_shift_next;
      gathered         <= gathered_next;
      clock_out        <= clock_out_next;
      lines_out        <= lines_out_next;
      lines_enabled    <= lines_enabled_next;
    end
  end

  clt_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd.valid),
    .push_ready (push_ready),
    .push_data  (step_res),
    .pop_valid  (pop_valid),
    .pop_ready  (res.ready),
    .pop_data   (pop_data)
  );

  assign res.valid              = pop_valid;
  assign res.clock_level        = pop_data.clock_level;
  assign res.line_drive         = pop_data.line_drive;
  assign res.line_output_enable = pop_data.line_output_enable;
  assign res.busy_res           = pop_data.busy_res;
  assign res.done_res           = pop_data.done_res;
  assign res.read_byte          = pop_data.read_byte;

  a_start_sets_active: assert property (@(posedge clk) disable iff (rst)
    push && !active && start |=> active)
    else $error("start word did not begin a transfer");

  a_done_ends_transfer: assert property (@(posedge clk) disable iff (rst)
    push && step_res.done_res |=> !active)
    else $error("transfer still active after done");

  a_read_byte_only_on_done: assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.read_byte != '0) |-> res.done_res)
    else $error("read byte shown outside a done word");

  a_stall_blocks_cmd: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> res.valid)
    else $error("cmd stalled with nothing pending on res");

endmodule
`default_nettype wire

// ----- sim/link_tick_checker.sv -----
`timescale 1ns / 1ps
module link_tick_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [clt_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [clt_pkg::CFG_DATA_W-1:0]  wr_data,
  clt_in_if                               cmd_mon,
  clt_out_if                              res_mon,
  output int                              failures,
  output int                              pending,
  output logic                            link_busy
);
  import clt_pkg::*;

  logic [1:0]  lane_mode;
  logic        clock_polarity;
  logic [15:0] low_ticks;
  logic [15:0] high_ticks;

  logic        active;
  logic        reading;
  logic        second_phase;
  logic [15:0] ticks_left;
  logic [3:0]  beats_left;
  logic [7:0]  send_shift;
  logic [7:0]  gathered;
  logic        clock_out;
  logic [7:0]  lines_out;
  logic        lines_enabled;

  res_t due_words[$];

  function automatic int lane_width(input logic [1:0] mode);
    case (mode)
      LANE_ONE:  return 1;
      LANE_FOUR: return 4;
      default:   return BYTE_W;
    endcase
  endfunction

  function automatic logic [15:0] ticks_or_one(input logic [15:0] t);
    return (t == 16'd0) ? 16'd1 : t;
  endfunction

  task automatic step_link(input logic [1:0] op, input logic [7:0] wbyte,
                           input logic [7:0] levels, output res_t word);
    int         w;
    logic [7:0] mask;
    logic       done;
    logic [7:0] rbyte;
    w = lane_width(lane_mode);
    mask = (w >= BYTE_W) ? 8'hFF : 8'((1 << w) - 1);
    done = 1'b0;
    rbyte = 8'd0;
    if (!active) begin
      clock_out = clock_polarity;
      if (op == OP_READ || op == OP_WRITE) begin
        active = 1'b1;
        reading = (op == OP_READ);
        second_phase = 1'b0;
        ticks_left = ticks_or_one(low_ticks);
        beats_left = 4'(BYTE_W / w);
        gathered = 8'd0;
        clock_out = ~clock_polarity;
        if (reading) begin
          lines_enabled = 1'b0;
        end else begin
          send_shift = wbyte;
          lines_enabled = 1'b1;
        end
      end
    end else begin
      if (ticks_left > 0) ticks_left--;
      if (ticks_left == 0) begin
        if (!second_phase) begin
          if (!reading) begin
            lines_out = send_shift & mask;
            send_shift = (w >= BYTE_W) ? 8'd0 : (send_shift >> w);
          end
          clock_out = clock_polarity;
          second_phase = 1'b1;
          ticks_left = ticks_or_one(high_ticks);
        end else begin
          if (reading) begin
            if (w >= BYTE_W) gathered = levels;
            else gathered = (gathered >> w) | ((levels & mask) << (BYTE_W - w));
          end
          if (beats_left > 0) beats_left--;
          if (beats_left == 0) begin
            active = 1'b0;
            second_phase = 1'b0;
            clock_out = clock_polarity;
            done = 1'b1;
            rbyte = reading ? gathered : 8'd0;
          end else begin
            second_phase = 1'b0;
            clock_out = ~clock_polarity;
            ticks_left = ticks_or_one(low_ticks);
          end
        end
      end
    end
    word.clock_level = clock_out;
    word.line_drive = lines_out;
    word.line_output_enable = lines_enabled;
    word.busy_res = active;
    word.done_res = done;
    word.read_byte = rbyte;
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      lane_mode = LANE_ONE;
      clock_polarity = 1'b1;
      low_ticks = 16'd1;
      high_ticks = 16'd1;
      active = 1'b0;
      reading = 1'b0;
      second_phase = 1'b0;
      ticks_left = 16'd0;
      beats_left = 4'd0;
      send_shift = 8'd0;
      gathered = 8'd0;
      clock_out = 1'b1;
      lines_out = 8'd0;
      lines_enabled = 1'b0;
      due_words.delete();
      failures = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_LANE_MODE:      lane_mode = wr_data[1:0];
          REG_CLOCK_POLARITY: clock_polarity = wr_data[0];
          REG_LOW_TICKS:      low_ticks = wr_data;
          REG_HIGH_TICKS:     high_ticks = wr_data;
          default: ;
        endcase
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        step_link(cmd_mon.operation, cmd_mon.write_byte, cmd_mon.line_levels, want);
        due_words.push_back(want);
      end
      if (res_mon.valid && res_mon.ready) begin
        if (due_words.size() == 0) begin
          $error("result word with nothing expected");
          failures++;
        end else begin
          want = due_words.pop_front();
          check_field("clock_level", want.clock_level, res_mon.clock_level);
          check_field("line_drive", want.line_drive, res_mon.line_drive);
          check_field("line_output_enable", want.line_output_enable,
                      res_mon.line_output_enable);
          check_field("busy_res", want.busy_res, res_mon.busy_res);
          check_field("done_res", want.done_res, res_mon.done_res);
          check_field("read_byte", want.read_byte, res_mon.read_byte);
        end
      end
    end
    pending = due_words.size();
    link_busy = active;
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import clt_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] LANE_SPARE = 2'd3;
  localparam int PHASES = 14;
  localparam int PHASE_WORDS = 60;

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;
  int                     failures;
  int                     pending;
  logic                   link_busy;
  bit                     no_gaps;
  int                     hold_requests;
  int                     holds_served;

  clt_in_if  cmd_ch ();
  clt_out_if res_ch ();

  clocked_lane_transfer_master dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cmd      (cmd_ch),
    .res      (res_ch)
  );

  link_tick_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .cmd_mon   (cmd_ch),
    .res_mon   (res_ch),
    .failures  (failures),
    .pending   (pending),
    .link_busy (link_busy)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int gap_left;
    int run_left;
    int hold_left;
    gap_left = 0;
    run_left = 0;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (no_gaps) begin
        res_ch.ready <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        res_ch.ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        res_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        gap_left = $urandom_range(1, 14) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        run_left = $urandom_range(1, 30) - 1;
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [7:0] wbyte,
                           input logic [7:0] levels);
    cmd_ch.valid <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.write_byte <= wbyte;
    cmd_ch.line_levels <= levels;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_for(input int cycles);
    cmd_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send_random_word();
    logic [1:0] op;
    int         pick;
    pick = $urandom_range(0, 99);
    if (!link_busy) begin
      if (pick < 35) op = OP_READ;
      else if (pick < 70) op = OP_WRITE;
      else if (pick < 88) op = OP_TICK;
      else op = OP_UNUSED;
    end else begin
      if (pick < 85) op = OP_TICK;
      else if (pick < 90) op = OP_READ;
      else if (pick < 95) op = OP_WRITE;
      else op = OP_UNUSED;
    end
    send_word(op, 8'($urandom), 8'($urandom));
  endtask

  task automatic write_regs(input logic [1:0] lane, input logic pol,
                            input logic [15:0] low, input logic [15:0] high);
    logic [CFG_INDEX_W-1:0] idx[4];
    logic [CFG_DATA_W-1:0]  vals[4];
    idx[0] = REG_LANE_MODE;
    idx[1] = REG_CLOCK_POLARITY;
    idx[2] = REG_LOW_TICKS;
    idx[3] = REG_HIGH_TICKS;
    vals[0] = 16'(lane);
    vals[1] = 16'(pol);
    vals[2] = low;
    vals[3] = high;
    for (int i = 0; i < 4; i++) begin
      wr_en <= 1'b1;
      wr_index <= idx[i];
      wr_data <= vals[i];
      @(negedge clk);
    end
    wr_en <= 1'b0;
  endtask

  // finish the transfer in flight, then drain the result words
  task automatic settle();
    while (link_busy) send_word(OP_TICK, 8'($urandom), 8'($urandom));
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_ticks();
    if ($urandom_range(0, 5) == 0) return 16'($urandom_range(5, 12));
    return 16'($urandom_range(0, 3));
  endfunction

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.operation = OP_TICK;
    cmd_ch.write_byte = 8'd0;
    cmd_ch.line_levels = 8'd0;
    no_gaps = 1'b0;
    hold_requests = 0;
    holds_served = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_word(OP_TICK, 8'hFF, 8'hFF);
    send_word(OP_UNUSED, 8'h00, 8'h00);
    settle();

    write_regs(LANE_EIGHT, 1'b0, 16'd0, 16'd0);
    send_word(OP_WRITE, 8'hFF, 8'h00);
    send_word(OP_READ, 8'h00, 8'h00);
    send_word(OP_TICK, 8'h00, 8'hFF);
    send_word(OP_WRITE, 8'h00, 8'hFF);
    send_word(OP_WRITE, 8'hFF, 8'hFF);
    send_word(OP_TICK, 8'hFF, 8'hFF);
    send_word(OP_READ, 8'hFF, 8'h00);
    send_word(OP_UNUSED, 8'h00, 8'h00);
    send_word(OP_TICK, 8'h00, 8'hFF);
    send_word(OP_READ, 8'hFF, 8'hFF);
    send_word(OP_TICK, 8'hFF, 8'hFF);
    send_word(OP_TICK, 8'hFF, 8'h00);
    send_word(OP_UNUSED, 8'hFF, 8'hFF);
    settle();

    // long beat: hold each clock level for the full tick count
    no_gaps = 1'b1;
    write_regs(LANE_EIGHT, 1'b1, 16'd40, 16'd33);
    send_word(OP_WRITE, 8'h5A, 8'hA5);
    settle();
    no_gaps = 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_regs(LANE_ONE, 1'b1, 16'd1, 16'd1);
        1: write_regs(LANE_FOUR, 1'b0, 16'd0, 16'd0);
        2: write_regs(LANE_SPARE, 1'b1, 16'd2, 16'd0);
        3: write_regs(LANE_ONE, 1'b0, 16'd0, 16'd3);
        PHASES - 1: begin
          no_gaps = 1'b1;
          write_regs(LANE_ONE, 1'b0, 16'd2, 16'd1);
        end
        default: write_regs(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            pick_ticks(), pick_ticks());
      endcase
      if (phase == 2) hold_requests++;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (phase == 4 && i == PHASE_WORDS / 2) begin
          cmd_ch.valid <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
        end else if (!no_gaps && $urandom_range(0, 7) == 0) begin
          idle_for($urandom_range(1, 14));
        end
        send_random_word();
      end
      settle();
    end

    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/clt_pkg.sv
rtl/core/clt_in_if.sv
rtl/core/clt_out_if.sv
rtl/core/clt_skid.sv
rtl/core/clocked_lane_transfer_master.sv
sim/link_tick_checker.sv
sim/tb_top.sv
